### rtl/clock_tree_frequency_calc_core_defines.svh
// Assertion macros for the clock tree frequency calculator.
// Used by the RTL modules in this folder; depends on nothing else.
`ifndef CLOCK_TREE_FREQUENCY_CALC_CORE_DEFINES_SVH
`define CLOCK_TREE_FREQUENCY_CALC_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CTFC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CTFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CTFC_ASSERT_IMPLIES(label, ante, cons)
`define CTFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/ctfc_pkg.sv
// Types, codes and helpers shared by the clock tree frequency calculator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ctfc_pkg;

    typedef enum logic [1:0] {
        SRC_INTERNAL   = 2'd0,
        SRC_EXTERNAL   = 2'd1,
        SRC_PLL        = 2'd2,
        SRC_INTERNAL_B = 2'd3
    } ctfc_src_t;

    localparam logic [1:0] CFG_INTERNAL_OSC = 2'd0;
    localparam logic [1:0] CFG_EXTERNAL_OSC = 2'd1;
    localparam logic [1:0] CFG_SHIFT_TABLE  = 2'd2;

    localparam logic [31:0] INTERNAL_OSC_RESET = 32'd16000000;
    localparam logic [31:0] EXTERNAL_OSC_RESET = 32'd25000000;
    localparam logic [31:0] RECIP_THREE        = 32'hAAAA_AAAB;
    localparam int          DIV_CELLS          = 32;

    // One snapshot in flight through the divider row
    typedef struct packed {
        logic [1:0]  sel;
        logic [3:0]  ahb_idx;
        logic [2:0]  apb1_idx;
        logic [2:0]  apb2_idx;
        logic [5:0]  m;
        logic [8:0]  n;
        logic [1:0]  pcode;
        logic [5:0]  rem;
        logic [31:0] dvd;
        logic [31:0] quo;
    } ctfc_item_t;

    function automatic logic [3:0] ctfc_shift(input logic [63:0] tbl, input logic [3:0] idx);
        return tbl[{idx, 2'b00} +: 4];
    endfunction

endpackage
`default_nettype wire

### rtl/ctfc_div_cell.sv
// One cell of the restoring divider row: produces one quotient bit per cell.
// Depends on ctfc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "clock_tree_frequency_calc_core_defines.svh"
module ctfc_div_cell
    import ctfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic       valid_in,
    input  wire ctfc_item_t item_in,
    output logic            valid_out,
    output ctfc_item_t      item_out
);

    logic       valid_reg;
    ctfc_item_t item_reg;
    ctfc_item_t item_next;
    logic [6:0] trial;
    logic       fits;

    always_comb
    begin
        trial     = {item_in.rem, item_in.dvd[31]};
        fits      = (trial >= {1'b0, item_in.m});
        item_next = item_in;
        item_next.dvd = {item_in.dvd[30:0], 1'b0};
        item_next.quo = {item_in.quo[30:0], fits};
        // divide-by-zero value is dropped later, so a truncated remainder is harmless
        item_next.rem = fits ? 6'(trial - {1'b0, item_in.m}) : trial[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

    `CTFC_ASSERT_IMPLIES(a_rem_below_m, valid_reg && item_reg.m != 6'd0, item_reg.rem < item_reg.m)
    `CTFC_ASSERT_NEXT(a_valid_moves, adv && valid_in, valid_reg)
    `CTFC_ASSERT_NEXT(a_hold_on_stall, !adv, $stable(valid_reg))

endmodule
`default_nettype wire

### rtl/clock_tree_frequency_calc_core.sv
// Throughput: one transaction per cycle while the output side is ready; the whole
// pipe (32 divider cells, multiply stage, post-divide stage, output register) holds on stall.
// Reset: rst_n clears all valid flags and reloads the oscillator registers (16 MHz,
// 25 MHz) and the shift table (zero). Depends on ctfc_pkg, ctfc_div_cell and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "clock_tree_frequency_calc_core_defines.svh"
module clock_tree_frequency_calc_core
    import ctfc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write port
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [1:0] source_select, [5:2] ahb_index, [8:6] apb1_index, [11:9] apb2_index,
    // [17:12] pll_input_div, [26:18] pll_multiplier, [28:27] pll_output_code,
    // [29] pll_from_external, [31:30] zero
    input  wire logic [31:0]  s_tdata,
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] system_hz, [63:32] ahb_hz, [95:64] apb1_hz, [127:96] apb2_hz,
    // [128] vco_wrapped, [135:129] zero
    output logic [135:0]      m_tdata
);

    // Configuration registers; the user must write them only while the pipe is empty (the block does not enforce this)
    logic [31:0] int_osc_reg;
    logic [31:0] ext_osc_reg;
    logic [63:0] shift_tbl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_osc_reg   <= INTERNAL_OSC_RESET;
            ext_osc_reg   <= EXTERNAL_OSC_RESET;
            shift_tbl_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERNAL_OSC: int_osc_reg   <= cfg_data[31:0];
                CFG_EXTERNAL_OSC: ext_osc_reg   <= cfg_data[31:0];
                CFG_SHIFT_TABLE:  shift_tbl_reg <= cfg_data;
                default:          ; // index out of range: drop the write
            endcase
        end
    end

    // Whole pipe advances together unless the output register is full and stalled
    logic adv;
    logic out_valid_reg;
    assign adv      = m_tready || !out_valid_reg;
    assign s_tready = adv;

    // Unpack the snapshot and load the dividend (the selected PLL reference)
    logic       cell_valid [0:DIV_CELLS];
    ctfc_item_t cell_item  [0:DIV_CELLS];

    always_comb
    begin
        cell_item[0].sel      = s_tdata[1:0];
        cell_item[0].ahb_idx  = s_tdata[5:2];
        cell_item[0].apb1_idx = s_tdata[8:6];
        cell_item[0].apb2_idx = s_tdata[11:9];
        cell_item[0].m        = s_tdata[17:12];
        cell_item[0].n        = s_tdata[26:18];
        cell_item[0].pcode    = s_tdata[28:27];
        cell_item[0].rem      = '0;
        cell_item[0].dvd      = s_tdata[29] ? ext_osc_reg : int_osc_reg;
        cell_item[0].quo      = '0;
    end
    assign cell_valid[0] = s_tvalid;

    // Row of divider cells: reference / M, one quotient bit per cell, MSB first
    genvar gi;
    generate
        for (gi = 0; gi < DIV_CELLS; gi++)
        begin : g_cell
            ctfc_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .valid_in  (cell_valid[gi]),
                .item_in   (cell_item[gi]),
                .valid_out (cell_valid[gi+1]),
                .item_out  (cell_item[gi+1])
            );
        end
    endgenerate

    // Multiply stage: VCO = (ref / M) * N, wrapping to 32 bits
    ctfc_item_t div_out;
    logic [31:0] vin;
    logic [40:0] prod;
    assign div_out = cell_item[DIV_CELLS];
    assign vin     = (div_out.m == 6'd0) ? 32'd0 : div_out.quo;
    assign prod    = vin * {23'd0, div_out.n};

    logic        a_valid_reg;
    logic [31:0] a_vco_reg;
    logic        a_wrap_reg;
    logic [1:0]  a_sel_reg;
    logic [1:0]  a_pcode_reg;
    logic [3:0]  a_ahb_reg;
    logic [2:0]  a_apb1_reg;
    logic [2:0]  a_apb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= cell_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_vco_reg   <= prod[31:0];
            a_wrap_reg  <= |prod[40:32];
            a_sel_reg   <= div_out.sel;
            a_pcode_reg <= div_out.pcode;
            a_ahb_reg   <= div_out.ahb_idx;
            a_apb1_reg  <= div_out.apb1_idx;
            a_apb2_reg  <= div_out.apb2_idx;
        end
    end

    // Post-divide by P = 2, 4, 6, 8: halve, then divide by 1..4;
    // divide by three through a reciprocal multiply
    logic [30:0] half;
    logic [63:0] third_prod;
    logic [31:0] pll_hz;
    logic [31:0] sys_next;
    logic        wrap_next;
    assign half       = a_vco_reg[31:1];
    assign third_prod = {33'd0, half} * {32'd0, RECIP_THREE};

    always_comb
    begin
        case (a_pcode_reg)
            2'd0:    pll_hz = {1'b0, half};
            2'd1:    pll_hz = {2'b0, half[30:1]};
            2'd2:    pll_hz = {1'b0, third_prod[63:33]};
            default: pll_hz = {3'b0, half[30:2]};
        endcase
        wrap_next = 1'b0;
        case (ctfc_src_t'(a_sel_reg))
            SRC_EXTERNAL:
            begin
                sys_next = ext_osc_reg;
            end
            SRC_PLL:
            begin
                sys_next  = pll_hz;
                wrap_next = a_wrap_reg;
            end
            default:
            begin
                sys_next = int_osc_reg;
            end
        endcase
    end

    logic        b_valid_reg;
    logic [31:0] b_sys_reg;
    logic        b_wrap_reg;
    logic [1:0]  b_sel_reg;
    logic [3:0]  b_ahb_reg;
    logic [2:0]  b_apb1_reg;
    logic [2:0]  b_apb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_sys_reg  <= sys_next;
            b_wrap_reg <= wrap_next;
            b_sel_reg  <= a_sel_reg;
            b_ahb_reg  <= a_ahb_reg;
            b_apb1_reg <= a_apb1_reg;
            b_apb2_reg <= a_apb2_reg;
        end
    end

    // Bus clocks: AHB from system, APB from AHB; APB indices read entries 0..7
    logic [31:0] ahb_next;
    logic [31:0] apb1_next;
    logic [31:0] apb2_next;
    assign ahb_next  = b_sys_reg >> ctfc_shift(shift_tbl_reg, b_ahb_reg);
    assign apb1_next = ahb_next >> ctfc_shift(shift_tbl_reg, {1'b0, b_apb1_reg});
    assign apb2_next = ahb_next >> ctfc_shift(shift_tbl_reg, {1'b0, b_apb2_reg});

    logic [31:0] sys_out_reg;
    logic [31:0] ahb_out_reg;
    logic [31:0] apb1_out_reg;
    logic [31:0] apb2_out_reg;
    logic        wrap_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sys_out_reg  <= b_sys_reg;
            ahb_out_reg  <= ahb_next;
            apb1_out_reg <= apb1_next;
            apb2_out_reg <= apb2_next;
            wrap_out_reg <= b_wrap_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, wrap_out_reg, apb2_out_reg, apb1_out_reg, ahb_out_reg, sys_out_reg};

    `CTFC_ASSERT_NEXT(a_accept_enters_row, s_tvalid && s_tready, cell_valid[1])
    `CTFC_ASSERT_IMPLIES(a_wrap_only_pll, b_valid_reg && b_wrap_reg, b_sel_reg == SRC_PLL)
    `CTFC_ASSERT_IMPLIES(a_bus_not_faster, out_valid_reg,
        ahb_out_reg <= sys_out_reg && apb1_out_reg <= ahb_out_reg && apb2_out_reg <= ahb_out_reg)

endmodule
`default_nettype wire
